[rtl/core/hsc_pkg.sv]
// ----------------------------------------------------------------------------
// hsc_pkg: shared types and constants of the Hamming codec
// Codeword geometry tables, register indexes, status codes and the
// structs that pass configuration and results between the modules.
// ----------------------------------------------------------------------------
package hsc_pkg;

    localparam int WORD_W = 63;
    localparam int POS_W  = 6;
    localparam int DATA_N = 57;
    localparam int PAR_N  = 6;

    // Register indexes on the configuration port
    localparam logic CFG_MODE      = 1'b0;
    localparam logic CFG_DATA_BITS = 1'b1;

    // Operating modes
    localparam logic MODE_ENCODE  = 1'b0;
    localparam logic MODE_CORRECT = 1'b1;

    // Result status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_CORR  = 2'd1;
    localparam logic [1:0] ST_RANGE = 2'd2;

    typedef logic [DATA_N-1:0][POS_W-1:0] idx_tab_t;
    typedef logic [PAR_N-1:0][POS_W-1:0]  par_tab_t;
    typedef logic [PAR_N-1:0][WORD_W-1:0] col_tab_t;

    typedef struct packed {
        logic             mode;
        logic [POS_W-1:0] cw_len;
    } cfg_t;

    typedef struct packed {
        logic [POS_W-1:0]  syndrome;
        logic [1:0]        status;
        logic [WORD_W-1:0] word;
    } res_t;

    // Bit index of each data bit inside the codeword (positions that are
    // not powers of two, taken in order).
    function automatic idx_tab_t build_data_idx();
        idx_tab_t tab;
        int       cnt;
        tab = '0;
        cnt = 0;
        for (int p = 1; p <= WORD_W; p++) begin
            if ((p & (p - 1)) != 0) begin
                tab[cnt] = POS_W'(p - 1);
                cnt++;
            end
        end
        return tab;
    endfunction

    function automatic par_tab_t build_par_idx();
        par_tab_t tab;
        for (int i = 0; i < PAR_N; i++) begin
            tab[i] = POS_W'((1 << i) - 1);
        end
        return tab;
    endfunction

    // Row i marks every position whose index has bit i set.
    function automatic col_tab_t build_col_mask();
        col_tab_t m;
        for (int i = 0; i < PAR_N; i++) begin
            for (int p = 1; p <= WORD_W; p++) begin
                m[i][p-1] = ((p >> i) & 1) != 0;
            end
        end
        return m;
    endfunction

    localparam idx_tab_t DATA_IDX = build_data_idx();
    localparam par_tab_t PAR_IDX  = build_par_idx();
    localparam col_tab_t COL_MASK = build_col_mask();

    // Codeword length for a given count of data bits.
    function automatic logic [POS_W-1:0] calc_cw_len(input logic [POS_W-1:0] d);
        logic [POS_W-1:0] n;
        if (d == 6'd0) begin
            n = 6'd0;
        end else if (d == 6'd1) begin
            n = 6'd3;
        end else if (d <= 6'd4) begin
            n = d + 6'd3;
        end else if (d <= 6'd11) begin
            n = d + 6'd4;
        end else if (d <= 6'd26) begin
            n = d + 6'd5;
        end else begin
            n = d + 6'd6;
        end
        return n;
    endfunction

endpackage

[rtl/core/hsc_cfg.sv]
// ----------------------------------------------------------------------------
// hsc_cfg: configuration registers
// Holds the mode and the codeword length derived from the data length,
// which is saturated to the largest supported value when written.
// ----------------------------------------------------------------------------
module hsc_cfg #(
    parameter int MAX_DATA_BITS = 57
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      cfg_we,
    input  logic                      cfg_addr,
    input  logic [hsc_pkg::POS_W-1:0] cfg_wdata,
    output hsc_pkg::cfg_t             cfg
);

    localparam logic [hsc_pkg::POS_W-1:0] MAX_D = hsc_pkg::POS_W'(MAX_DATA_BITS);
    localparam logic [hsc_pkg::POS_W-1:0] RESET_LEN = hsc_pkg::calc_cw_len(MAX_D);

    logic                      mode_reg;
    logic [hsc_pkg::POS_W-1:0] cw_len_reg;
    logic [hsc_pkg::POS_W-1:0] d_sat;

    assign d_sat = (cfg_wdata > MAX_D) ? MAX_D : cfg_wdata;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg   <= hsc_pkg::MODE_ENCODE;
            cw_len_reg <= RESET_LEN;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                hsc_pkg::CFG_MODE:      mode_reg   <= cfg_wdata[0];
                hsc_pkg::CFG_DATA_BITS: cw_len_reg <= hsc_pkg::calc_cw_len(d_sat);
                default: ;
            endcase
        end
    end

    assign cfg.mode   = mode_reg;
    assign cfg.cw_len = cw_len_reg;

endmodule

[rtl/core/hsc_xform.sv]
// ----------------------------------------------------------------------------
// hsc_xform: encode and correct datapath
// XOR trees that build the codeword, or compute the syndrome, repair one
// bit and strip the parity positions.
// ----------------------------------------------------------------------------
module hsc_xform #(
    parameter int MAX_DATA_BITS = 57
) (
    input  hsc_pkg::cfg_t                cfg,
    input  logic [hsc_pkg::WORD_W-1:0]   word,
    output hsc_pkg::res_t                res
);

    logic [hsc_pkg::WORD_W-1:0] pos_ok;
    logic [hsc_pkg::WORD_W-1:0] enc_data;
    logic [hsc_pkg::WORD_W-1:0] enc_word;
    logic [hsc_pkg::PAR_N-1:0]  enc_par;
    logic [hsc_pkg::WORD_W-1:0] cw_in;
    logic [hsc_pkg::POS_W-1:0]  syn;
    logic                       syn_in_range;
    logic [hsc_pkg::WORD_W-1:0] fixed;
    logic [hsc_pkg::WORD_W-1:0] dec_word;

    genvar j, i;

    // Only positions up to the codeword length take part.
    generate
        for (j = 0; j < hsc_pkg::WORD_W; j++) begin : g_pos
            assign pos_ok[j] = hsc_pkg::POS_W'(j + 1) <= cfg.cw_len;
            assign fixed[j]  = cw_in[j] ^
                               (syn_in_range && (syn == hsc_pkg::POS_W'(j + 1)));
        end
    endgenerate

    assign cw_in = word & pos_ok;

    always_comb begin
        enc_data = '0;
        dec_word = '0;
        for (int n = 0; n < MAX_DATA_BITS; n++) begin
            enc_data[hsc_pkg::DATA_IDX[n]] = word[n] & pos_ok[hsc_pkg::DATA_IDX[n]];
            dec_word[n] = fixed[hsc_pkg::DATA_IDX[n]];
        end
    end

    generate
        for (i = 0; i < hsc_pkg::PAR_N; i++) begin : g_par
            assign enc_par[i] = ^(enc_data & hsc_pkg::COL_MASK[i]);
            assign syn[i]     = ^(cw_in & hsc_pkg::COL_MASK[i]);
        end
    endgenerate

    always_comb begin
        enc_word = enc_data;
        for (int n = 0; n < hsc_pkg::PAR_N; n++) begin
            enc_word[hsc_pkg::PAR_IDX[n]] = enc_par[n] & pos_ok[hsc_pkg::PAR_IDX[n]];
        end
    end

    assign syn_in_range = (syn != '0) && (syn <= cfg.cw_len);

    always_comb begin
        if (cfg.mode == hsc_pkg::MODE_ENCODE) begin
            res.word     = enc_word;
            res.status   = hsc_pkg::ST_OK;
            res.syndrome = '0;
        end else begin
            res.word     = dec_word;
            res.syndrome = syn;
            if (syn == '0) begin
                res.status = hsc_pkg::ST_OK;
            end else if (syn_in_range) begin
                res.status = hsc_pkg::ST_CORR;
            end else begin
                res.status = hsc_pkg::ST_RANGE;
            end
        end
    end

endmodule

[rtl/core/hamming_sec_codec.sv]
// ----------------------------------------------------------------------------
// hamming_sec_codec: Hamming single-error-correcting encoder and corrector
// Stream in, stream out; one word per beat, one result per word.
// ----------------------------------------------------------------------------
// Usage:
//   The slave channel takes one word per beat in s_tdata. In encode mode
//   the low data_bits bits are placed into a codeword; in correct mode the
//   word is read as a codeword, the syndrome is computed and the bit that
//   it names is flipped before the data bits are extracted.
//   The master channel returns word_out, status and syndrome per beat.
//   Registers are written through cfg_we/cfg_addr/cfg_wdata while idle:
//   index 0 is the mode, index 1 the data length.
//   m_tvalid rises when the result register takes the word's result: one
//   input register and one result register, with the XOR trees between
//   them. Throughput is one word per cycle while m_tready stays high;
//   the result register is the only limit and it reloads on the edge at
//   which its beat is taken.
//   Reset clears both valid flags and sets encode mode with 57 data bits
//   (limited to MAX_DATA_BITS). When the receiver holds m_tready low the
//   result is held, the input register fills, and then s_tready drops.
// ----------------------------------------------------------------------------
module hamming_sec_codec #(
    parameter int MAX_DATA_BITS = 57
) (
    input  logic        aclk,
    input  logic        aresetn,
    // configuration write port
    input  logic        cfg_we,
    input  logic        cfg_addr,
    input  logic [5:0]  cfg_wdata,
    // slave channel
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // [62:0] word_in, [63] zero
    // master channel
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata    // [62:0] word_out, [64:63] status,
                                   // [70:65] syndrome, [71] zero
);

    hsc_pkg::cfg_t cfg;
    hsc_pkg::res_t res;

    logic                        in_valid_reg;
    logic [hsc_pkg::WORD_W-1:0]  in_word_reg;
    logic                        out_valid_reg;
    hsc_pkg::res_t               out_res_reg;
    logic                        out_ready;
    logic                        load_out;

    hsc_cfg #(
        .MAX_DATA_BITS(MAX_DATA_BITS)
    ) u_cfg (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_we   (cfg_we),
        .cfg_addr (cfg_addr),
        .cfg_wdata(cfg_wdata),
        .cfg      (cfg)
    );

    hsc_xform #(
        .MAX_DATA_BITS(MAX_DATA_BITS)
    ) u_xform (
        .cfg (cfg),
        .word(in_word_reg),
        .res (res)
    );

    assign out_ready = !out_valid_reg || m_tready;
    assign load_out  = in_valid_reg && out_ready;
    assign s_tready  = !in_valid_reg || out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            if (out_ready) begin
                out_valid_reg <= in_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_word_reg <= s_tdata[hsc_pkg::WORD_W-1:0];
        end
        if (load_out) begin
            out_res_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, out_res_reg};

    // A word waiting in the input register is never dropped while stalled.
    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && !out_ready |=> in_valid_reg)
        else $error("input beat lost during stall");

    // Loading the result register always presents a beat.
    a_load_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        load_out |=> m_tvalid)
        else $error("result loaded without valid");

    // Encode results carry no syndrome and no error status.
    a_enc_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        load_out && (cfg.mode == hsc_pkg::MODE_ENCODE) |=>
        (out_res_reg.syndrome == '0) && (out_res_reg.status == hsc_pkg::ST_OK))
        else $error("encode result with syndrome or status");

    // An out-of-range status implies a syndrome beyond the codeword length.
    a_range: assert property (@(posedge aclk) disable iff (!aresetn)
        load_out && (res.status == hsc_pkg::ST_RANGE) |=>
        out_res_reg.syndrome > $past(cfg.cw_len))
        else $error("range status with syndrome inside codeword");

endmodule

[bench/hamming_sec_codec_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hamming_sec_codec_tb: self-checking bench for the Hamming SEC codec
// Drives words through both modes over a range of data lengths, including
// empty and saturated lengths, clean, single-error, double-error and noise
// codewords. Every result beat is compared with a local prediction, while
// both stream sides idle at random and the receiver holds off once for long.
// ----------------------------------------------------------------------------
module hamming_sec_codec_tb;

    localparam int LIMIT_CYCLES = 200000;
    localparam int ITEMS_PER_PHASE = 48;

    // Keeps a copy of the registers, predicts each result and checks the
    // result beats in order.
    class hamming_scoreboard;
        localparam int LEN_CAP = 57;

        logic          mode;
        logic [5:0]    data_bits;
        hsc_pkg::res_t pending_results[$];
        int            errors;
        int            beats_in;
        int            results_seen;

        function new();
            mode         = hsc_pkg::MODE_ENCODE;
            data_bits    = 6'd57;
            errors       = 0;
            beats_in     = 0;
            results_seen = 0;
        endfunction

        function void set_reg(logic addr, logic [5:0] value);
            if (addr == hsc_pkg::CFG_MODE) begin
                mode = value[0];
            end else begin
                data_bits = value;
            end
        endfunction

        function int data_len();
            return (data_bits > LEN_CAP) ? LEN_CAP : int'(data_bits);
        endfunction

        function int codeword_len();
            int d;
            int r;
            d = data_len();
            r = 0;
            while ((1 << r) < r + d + 1) r++;
            return (d == 0) ? 0 : d + r;
        endfunction

        static function bit is_parity_pos(int p);
            return (p & (p - 1)) == 0;
        endfunction

        function logic [62:0] encode_word(logic [62:0] data);
            logic [62:0] cw;
            logic [5:0]  acc;
            int          n;
            int          k;
            n   = codeword_len();
            cw  = '0;
            acc = '0;
            k   = 0;
            for (int p = 1; p <= n; p++) begin
                if (!is_parity_pos(p)) begin
                    if (data[k]) begin
                        cw[p-1] = 1'b1;
                        acc ^= 6'(p);
                    end
                    k++;
                end
            end
            // Parity bits make the XOR of all set positions zero.
            for (int i = 0; i < 6; i++) begin
                if ((1 << i) <= n && acc[i]) cw[(1 << i) - 1] = 1'b1;
            end
            return cw;
        endfunction

        function hsc_pkg::res_t predict(logic [62:0] w);
            hsc_pkg::res_t r;
            int            n;
            int            k;
            r = '0;
            n = codeword_len();
            k = 0;
            if (mode == hsc_pkg::MODE_ENCODE) begin
                r.word = encode_word(w);
            end else begin
                for (int p = 1; p <= n; p++) begin
                    if (w[p-1]) r.syndrome ^= 6'(p);
                end
                if (r.syndrome != 6'd0) begin
                    if (int'(r.syndrome) <= n) begin
                        w[r.syndrome - 6'd1] = ~w[r.syndrome - 6'd1];
                        r.status = hsc_pkg::ST_CORR;
                    end else begin
                        r.status = hsc_pkg::ST_RANGE;
                    end
                end
                for (int p = 1; p <= n; p++) begin
                    if (!is_parity_pos(p)) begin
                        r.word[k] = w[p-1];
                        k++;
                    end
                end
            end
            return r;
        endfunction

        function void note_word(logic [62:0] w);
            pending_results.push_back(predict(w));
            beats_in++;
        endfunction

        function int outstanding();
            return pending_results.size();
        endfunction

        task report(string what);
            errors++;
            if (errors <= 40) $display("MISMATCH at %0t: %s", $realtime, what);
        endtask

        task check_result(logic [71:0] beat);
            hsc_pkg::res_t got;
            hsc_pkg::res_t want;
            got = hsc_pkg::res_t'(beat[70:0]);
            results_seen++;
            if (pending_results.size() == 0) begin
                report($sformatf("result beat %h with nothing outstanding", beat));
            end else begin
                want = pending_results.pop_front();
                if (got.word !== want.word)
                    report($sformatf("word %h, predicted %h", got.word, want.word));
                if (got.status !== want.status)
                    report($sformatf("status %0d, predicted %0d", got.status, want.status));
                if (got.syndrome !== want.syndrome)
                    report($sformatf("syndrome %0d, predicted %0d",
                                     got.syndrome, want.syndrome));
            end
        endtask
    endclass

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_we = 1'b0;
    logic        cfg_addr = 1'b0;
    logic [5:0]  cfg_wdata = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [63:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [71:0] m_tdata;

    logic        calm = 1'b0;
    logic        hold_request = 1'b0;
    logic        hold_off = 1'b0;
    int          rx_stall = 0;
    int          cycle_count = 0;
    int          settings_run = 0;

    hamming_scoreboard book = new();

    hamming_sec_codec dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("Timed out with %0d results outstanding", book.outstanding());
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Receiver: checks every accepted result beat and stalls in bursts.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) book.check_result(m_tdata);
        if (rx_stall > 0) begin
            rx_stall--;
        end else if (!calm && $urandom_range(0, 6) == 0) begin
            rx_stall = $urandom_range(1, 11);
        end
        m_tready <= (rx_stall == 0) && !hold_off;
    end

    // One long hold-off on the result side, so that the block backs up and
    // drops s_tready while the sender keeps offering beats.
    initial begin
        wait (hold_request);
        @(posedge aclk);
        hold_off <= 1'b1;
        repeat (150) @(posedge aclk);
        hold_off <= 1'b0;
    end

    function automatic logic [62:0] random_word();
        logic [63:0] raw;
        raw = {$urandom(), $urandom()};
        return raw[62:0];
    endfunction

    task automatic send_word(input logic [62:0] w);
        if (!calm && $urandom_range(0, 6) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {1'b0, w};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        book.note_word(w);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (book.outstanding() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    // Leaves the write enable high; the caller drops it after its last write.
    task automatic write_reg(input logic addr, input logic [5:0] value);
        cfg_we    <= 1'b1;
        cfg_addr  <= addr;
        cfg_wdata <= value;
        @(posedge aclk);
        book.set_reg(addr, value);
    endtask

    task automatic configure(input logic mode, input logic [5:0] len);
        drain();
        write_reg(hsc_pkg::CFG_MODE, {5'd0, mode});
        write_reg(hsc_pkg::CFG_DATA_BITS, len);
        cfg_we <= 1'b0;
        settings_run++;
    endtask

    // Random traffic for the current setting. In correct mode most words are
    // real codewords, clean or with one flipped position; the rest are
    // double errors and noise, which reach the out-of-range syndromes.
    task automatic random_phase(input int count);
        logic [62:0] w;
        int          n;
        int          pick;
        for (int i = 0; i < count; i++) begin
            n    = book.codeword_len();
            pick = $urandom_range(0, 9);
            if (book.mode == hsc_pkg::MODE_ENCODE || n == 0) begin
                w = random_word();
            end else begin
                w = book.encode_word(random_word());
                if (pick >= 4 && pick <= 8) w[$urandom_range(0, n - 1)] ^= 1'b1;
                if (pick == 8) w[$urandom_range(0, n - 1)] ^= 1'b1;
                if (pick == 9) w = random_word();
                // Now and then junk above the codeword, which must be ignored.
                if ($urandom_range(0, 7) == 0) w |= random_word() & ~((63'd1 << n) - 63'd1);
            end
            send_word(w);
        end
    endtask

    initial begin
        logic [62:0] cw;
        int          len_table[14];

        len_table = '{57, 1, 63, 4, 11, 26, 0, 2, 5, 12, 27, 58, 33, 57};

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Encode at full length: extremes and patterns.
        configure(hsc_pkg::MODE_ENCODE, 6'd57);
        send_word('0);
        send_word({63{1'b1}});
        send_word(63'd1);
        send_word(63'd1 << 56);
        send_word(63'h2AAA_AAAA_AAAA_AAAA);

        // Correct at full length: errors at the first and the last position.
        configure(hsc_pkg::MODE_CORRECT, 6'd57);
        cw = book.encode_word(63'h0123_4567_89AB_CDEF);
        send_word('0);
        send_word({63{1'b1}});
        send_word(cw);
        send_word(cw ^ 63'd1);
        send_word(cw ^ (63'd1 << 62));

        // Short codeword of nine positions: a syndrome of ten lies outside it.
        configure(hsc_pkg::MODE_CORRECT, 6'd5);
        send_word(63'h82);
        send_word({63{1'b1}});

        // Empty codeword in both modes.
        configure(hsc_pkg::MODE_ENCODE, 6'd0);
        send_word({63{1'b1}});
        configure(hsc_pkg::MODE_CORRECT, 6'd0);
        send_word({63{1'b1}});

        // Lengths above the limit saturate.
        configure(hsc_pkg::MODE_ENCODE, 6'd63);
        send_word({63{1'b1}});
        configure(hsc_pkg::MODE_CORRECT, 6'd60);
        send_word(random_word());

        // Single data bit, and an error on its only data position.
        configure(hsc_pkg::MODE_ENCODE, 6'd1);
        send_word(63'd1);
        configure(hsc_pkg::MODE_CORRECT, 6'd1);
        send_word(book.encode_word(63'd1) ^ 63'b100);

        for (int ph = 0; ph < 14; ph++) begin
            if (ph >= 12) calm <= 1'b1;
            configure(logic'(ph % 2), 6'(len_table[ph]));
            if (ph == 2) begin
                random_phase(10);
                hold_request <= 1'b1;
                random_phase(ITEMS_PER_PHASE - 10);
            end else begin
                random_phase(ITEMS_PER_PHASE);
            end
        end

        drain();
        repeat (10) @(posedge aclk);
        book.errors += book.outstanding();

        $display("Covered %0d words in, %0d results checked, over %0d register settings",
                 book.beats_in, book.results_seen, settings_run);
        $display("in both modes, data lengths 0 to 63, with stalls on both sides.");
        if (book.errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
